// ===== src/tprc_pkg.sv =====
// ----------------------------------------------------------------------------
// tprc_pkg
// Shared widths, constants, types and helpers of the thermal pixel
// radiometric correction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tprc_pkg;

   localparam int TEMP_W     = 19;
   localparam int EMIS_W     = 17;
   localparam int DIST_W     = 16;
   localparam int HUM_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_EMISSIVITY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFLECTED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATMOSPHERE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMIDITY   = 3'd4;

   localparam int KELVIN_K = 27315;
   localparam int OUT_LOW  = -10000;
   localparam int OUT_HIGH = 150000;

   localparam int MAG_W     = 19;
   localparam int SQ_W      = 28;
   localparam int POW_W     = 56;
   localparam int SUM_W     = 64;
   localparam int ROOT_W    = 32;
   localparam int SQ_STAGES = 32;
   localparam int K2_W      = 22;

   localparam logic [63:0] EXP_A   = 64'd7146825581;
   localparam logic [63:0] EXP_B   = 64'd167772;
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam int TAYLOR_TERMS     = 12;

   localparam int MD_W     = 64;
   localparam int MD_STEPS = 64;
   localparam int MD_CNT_W = $clog2(MD_STEPS);

   typedef struct packed {
      logic            start;
      logic            op_div;
      logic [MD_W-1:0] a;
      logic [MD_W-1:0] b;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [2*MD_W-1:0] res;
   } md_rsp_type;

   // magnitude of the kelvin value in 0.01 K
   function automatic logic [MAG_W-1:0] kelvin_mag(input logic signed [TEMP_W-1:0] t);
      logic signed [TEMP_W:0] k;
      k = $signed({t[TEMP_W-1], t}) + $signed((TEMP_W+1)'(KELVIN_K));
      if (k < 0) begin
         kelvin_mag = MAG_W'(-k);
      end else begin
         kelvin_mag = MAG_W'(k);
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/tprc_if.sv =====
// ----------------------------------------------------------------------------
// tprc channel interfaces
// Pixel request and corrected pixel response channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tprc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tprc_pkg::TEMP_W-1:0]    raw_temp;
   modport source (output valid, output raw_temp, input ready);
   modport sink   (input valid, input raw_temp, output ready);
endinterface

interface tprc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tprc_pkg::TEMP_W-1:0]    corrected_temp;
   logic                                  saturated;
   modport source (output valid, output corrected_temp, output saturated, input ready);
   modport sink   (input valid, input corrected_temp, input saturated, output ready);
endinterface

`default_nettype wire

// ===== src/tprc_muldiv.sv =====
// ----------------------------------------------------------------------------
// tprc_muldiv
// Shared bit-serial unit: 64x64 shift-add multiply or 64/64 restoring
// divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tprc_muldiv (
   input  wire                     clock,
   input  wire                     reset,
   input  tprc_pkg::md_req_type    md_req,
   output tprc_pkg::md_rsp_type    md_rsp
);

   localparam int W = tprc_pkg::MD_W;

   logic [2*W-1:0]               acc_ff;
   logic [2*W-1:0]               ma_ff;
   logic [W-1:0]                 mb_ff;
   logic [tprc_pkg::MD_CNT_W-1:0] cnt_ff;
   logic                         run_ff;
   logic                         div_ff;
   logic                         done_ff;

   logic [W:0]     rem_sh;
   logic [W:0]     dvs;
   logic           ge;
   logic [W:0]     rem_new;
   logic [2*W-1:0] acc_in;

   always_comb begin
      rem_sh  = {acc_ff[2*W-1:W], acc_ff[W-1]};
      dvs     = {1'b0, ma_ff[W-1:0]};
      ge      = rem_sh >= dvs;
      rem_new = ge ? rem_sh - dvs : rem_sh;
      if (div_ff) begin
         acc_in = {rem_new[W-1:0], acc_ff[W-2:0], ge};
      end else begin
         acc_in = mb_ff[0] ? acc_ff + ma_ff : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         div_ff  <= 1'b0;
      end else if (md_req.start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         div_ff  <= md_req.op_div;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == tprc_pkg::MD_CNT_W'(tprc_pkg::MD_STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (md_req.start) begin
         if (md_req.op_div) begin
            acc_ff <= {{W{1'b0}}, md_req.a};
            ma_ff  <= {{W{1'b0}}, md_req.b};
         end else begin
            acc_ff <= '0;
            ma_ff  <= {{W{1'b0}}, md_req.a};
         end
         mb_ff <= md_req.b;
      end else if (run_ff) begin
         acc_ff <= acc_in;
         if (!div_ff) begin
            ma_ff <= {ma_ff[2*W-2:0], 1'b0};
         end
         mb_ff <= {1'b0, mb_ff[W-1:1]};
      end
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.res  = acc_ff;

endmodule

`default_nettype wire

// ===== src/tprc_coef.sv =====
// ----------------------------------------------------------------------------
// tprc_coef
// Control registers and the sequencer that derives the constant
// reflected plus atmospheric term from them on the shared serial unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tprc_coef (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_wen,
   input  wire  [tprc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [tprc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output tprc_pkg::md_req_type                   md_req,
   input  tprc_pkg::md_rsp_type                   md_rsp,
   output logic                                   busy,
   output logic [tprc_pkg::SUM_W-1:0]             const_term
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_HMUL  = 4'd1;
   localparam logic [3:0] ST_XMUL  = 4'd2;
   localparam logic [3:0] ST_TMUL  = 4'd3;
   localparam logic [3:0] ST_TDIV  = 4'd4;
   localparam logic [3:0] ST_CRDIV = 4'd5;
   localparam logic [3:0] ST_ETMUL = 4'd6;
   localparam logic [3:0] ST_CADIV = 4'd7;
   localparam logic [3:0] ST_SQ1   = 4'd8;
   localparam logic [3:0] ST_SQ2   = 4'd9;
   localparam logic [3:0] ST_PMUL  = 4'd10;

   localparam int W = tprc_pkg::MD_W;

   logic [tprc_pkg::EMIS_W-1:0]        emis_ff;
   logic signed [tprc_pkg::TEMP_W-1:0] refl_ff;
   logic signed [tprc_pkg::TEMP_W-1:0] atm_ff;
   logic [tprc_pkg::DIST_W-1:0]        dist_ff;
   logic [tprc_pkg::HUM_W-1:0]         hum_ff;

   logic [3:0]  state_ff;
   logic [3:0]  state_in;
   logic        pend_ff;
   logic        side_ff;

   logic [W-1:0]                 t_ff;
   logic [31:0]                  x32_ff;
   logic [W-1:0]                 term_ff;
   logic [W-1:0]                 sum_ff;
   logic [3:0]                   n_ff;
   logic [W-1:0]                 tprod_ff;
   logic [32:0]                  tau_ff;
   logic [23:0]                  cr_ff;
   logic [49:0]                  et_ff;
   logic [23:0]                  ca_ff;
   logic [tprc_pkg::SQ_W-1:0]    sq_ff;
   logic [tprc_pkg::POW_W-1:0]   pw_ff;
   logic [tprc_pkg::SUM_W-1:0]   acc_ff;

   logic [tprc_pkg::EMIS_W-1:0] e_c;
   logic [tprc_pkg::DIST_W-1:0] od_c;
   logic [tprc_pkg::HUM_W-1:0]  h_c;
   logic [tprc_pkg::MAG_W-1:0]  mag_s;
   logic [2*W-1:0]              res;
   logic                        fin;
   logic                        x_big;
   logic [W-1:0]                sum_next;
   logic [32:0]                 tau_clamp;
   logic [32:0]                 tau_diff;
   logic [tprc_pkg::EMIS_W-1:0] e_rest;

   always_comb begin
      if (emis_ff < 17'd655) begin
         e_c = 17'd655;
      end else if (emis_ff > 17'd65536) begin
         e_c = 17'd65536;
      end else begin
         e_c = emis_ff;
      end
      od_c     = (dist_ff < 16'd26) ? 16'd26 : dist_ff;
      h_c      = (hum_ff > 17'd65536) ? 17'd65536 : hum_ff;
      mag_s    = side_ff ? tprc_pkg::kelvin_mag(atm_ff) : tprc_pkg::kelvin_mag(refl_ff);
      res      = md_rsp.res;
      fin      = pend_ff && md_rsp.done;
      x_big    = res[63:16] >= 48'(tprc_pkg::LN2_Q32);
      sum_next = n_ff[0] ? sum_ff - res[W-1:0] : sum_ff + res[W-1:0];
      if (sum_next < 64'h0000_0000_8000_0000) begin
         tau_clamp = 33'h0_8000_0000;
      end else if (sum_next > 64'h0000_0001_0000_0000) begin
         tau_clamp = 33'h1_0000_0000;
      end else begin
         tau_clamp = sum_next[32:0];
      end
      tau_diff = 33'h1_0000_0000 - tau_ff;
      e_rest   = 17'd65536 - e_c;
   end

   // operand selection for the serial unit
   always_comb begin
      md_req.start  = (state_ff != ST_IDLE) && !pend_ff;
      md_req.op_div = 1'b0;
      md_req.a      = '0;
      md_req.b      = '0;
      case (state_ff)
         ST_HMUL: begin
            md_req.a = tprc_pkg::EXP_B;
            md_req.b = W'(h_c);
         end
         ST_XMUL: begin
            md_req.a = tprc_pkg::EXP_A + t_ff;
            md_req.b = W'(od_c);
         end
         ST_TMUL: begin
            md_req.a = term_ff;
            md_req.b = W'(x32_ff);
         end
         ST_TDIV: begin
            md_req.op_div = 1'b1;
            md_req.a      = tprod_ff;
            md_req.b      = W'(n_ff);
         end
         ST_CRDIV: begin
            md_req.op_div = 1'b1;
            md_req.a      = W'({e_rest, 16'b0});
            md_req.b      = W'(e_c);
         end
         ST_ETMUL: begin
            md_req.a = W'(e_c);
            md_req.b = W'(tau_ff);
         end
         ST_CADIV: begin
            md_req.op_div = 1'b1;
            md_req.a      = {tau_diff[31:0], 32'b0};
            md_req.b      = W'(et_ff);
         end
         ST_SQ1: begin
            md_req.a = W'(mag_s);
            md_req.b = W'(mag_s);
         end
         ST_SQ2: begin
            md_req.a = W'(sq_ff);
            md_req.b = W'(sq_ff);
         end
         ST_PMUL: begin
            md_req.a = W'(pw_ff);
            md_req.b = side_ff ? W'(ca_ff) : W'(cr_ff);
         end
         default: begin
            md_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_HMUL:  state_in = ST_XMUL;
         ST_XMUL:  state_in = x_big ? ST_CRDIV : ST_TMUL;
         ST_TMUL:  state_in = ST_TDIV;
         ST_TDIV:  state_in = (n_ff == 4'(tprc_pkg::TAYLOR_TERMS)) ? ST_CRDIV : ST_TMUL;
         ST_CRDIV: state_in = ST_ETMUL;
         ST_ETMUL: state_in = ST_CADIV;
         ST_CADIV: state_in = ST_SQ1;
         ST_SQ1:   state_in = ST_SQ2;
         ST_SQ2:   state_in = ST_PMUL;
         ST_PMUL:  state_in = side_ff ? ST_IDLE : ST_SQ1;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emis_ff  <= 17'd62259;
         refl_ff  <= 19'sd2500;
         atm_ff   <= 19'sd2500;
         dist_ff  <= 16'd256;
         hum_ff   <= 17'd32768;
         state_ff <= ST_HMUL;
         pend_ff  <= 1'b0;
         side_ff  <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            tprc_pkg::CSR_EMISSIVITY: emis_ff <= csr_wdata[tprc_pkg::EMIS_W-1:0];
            tprc_pkg::CSR_REFLECTED:  refl_ff <= $signed(csr_wdata);
            tprc_pkg::CSR_ATMOSPHERE: atm_ff  <= $signed(csr_wdata);
            tprc_pkg::CSR_DISTANCE:   dist_ff <= csr_wdata[tprc_pkg::DIST_W-1:0];
            tprc_pkg::CSR_HUMIDITY:   hum_ff  <= csr_wdata[tprc_pkg::HUM_W-1:0];
            default: ;
         endcase
         state_ff <= ST_HMUL;
         pend_ff  <= 1'b0;
         side_ff  <= 1'b0;
      end else if (state_ff != ST_IDLE) begin
         if (!pend_ff) begin
            pend_ff <= 1'b1;
         end else if (md_rsp.done) begin
            pend_ff  <= 1'b0;
            state_ff <= state_in;
            if (state_ff == ST_PMUL) begin
               side_ff <= !side_ff;
            end
         end
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (fin) begin
         case (state_ff)
            ST_HMUL: t_ff <= res[W-1:0];
            ST_XMUL: begin
               if (x_big) begin
                  tau_ff <= 33'h0_8000_0000;
               end else begin
                  x32_ff  <= res[47:16];
                  term_ff <= 64'h0000_0001_0000_0000;
                  sum_ff  <= 64'h0000_0001_0000_0000;
                  n_ff    <= 4'd1;
               end
            end
            ST_TMUL: tprod_ff <= res[95:32];
            ST_TDIV: begin
               term_ff <= res[W-1:0];
               sum_ff  <= sum_next;
               n_ff    <= n_ff + 4'd1;
               tau_ff  <= tau_clamp;
            end
            ST_CRDIV: cr_ff <= res[23:0];
            ST_ETMUL: et_ff <= res[49:0];
            ST_CADIV: ca_ff <= res[23:0];
            ST_SQ1:   sq_ff <= res[37:10];
            ST_SQ2:   pw_ff <= res[tprc_pkg::POW_W-1:0];
            ST_PMUL:  acc_ff <= side_ff ? acc_ff + res[79:16] : res[79:16];
            default: ;
         endcase
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign const_term = acc_ff;

endmodule

`default_nettype wire

// ===== src/tprc_isqrt.sv =====
// ----------------------------------------------------------------------------
// tprc_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per
// stage, 32 stages, stall by a common advance.
// ----------------------------------------------------------------------------
`default_nettype none

module tprc_isqrt (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  wire                              in_valid,
   input  wire  [2*tprc_pkg::ROOT_W-1:0]    in_value,
   output logic                             out_valid,
   output logic [tprc_pkg::ROOT_W-1:0]      out_root
);

   localparam int N  = tprc_pkg::SQ_STAGES;
   localparam int RW = tprc_pkg::ROOT_W;
   localparam int VW = 2 * RW;
   localparam int MW = RW + 2;

   logic [MW-1:0] rem_ff  [N];
   logic [RW-1:0] root_ff [N];
   logic [VW-1:0] val_ff  [N];
   logic [MW-1:0] rem_in  [N];
   logic [RW-1:0] root_in [N];
   logic [VW-1:0] val_in  [N];
   logic [N-1:0]  vld_ff;

   always_comb begin
      logic [MW+1:0] cur;
      logic [MW+1:0] trial;
      logic [MW+1:0] diff;
      logic [MW-1:0] s_rem;
      logic [RW-1:0] s_root;
      logic [VW-1:0] s_val;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            s_rem  = '0;
            s_root = '0;
            s_val  = in_value;
         end else begin
            s_rem  = rem_ff[i-1];
            s_root = root_ff[i-1];
            s_val  = val_ff[i-1];
         end
         cur   = {s_rem, s_val[VW-1:VW-2]};
         trial = {2'b00, s_root, 2'b01};
         diff  = cur - trial;
         if (cur >= trial) begin
            rem_in[i]  = diff[MW-1:0];
            root_in[i] = {s_root[RW-2:0], 1'b1};
         end else begin
            rem_in[i]  = cur[MW-1:0];
            root_in[i] = {s_root[RW-2:0], 1'b0};
         end
         val_in[i] = {s_val[VW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < N; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            val_ff[i]  <= val_in[i];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

`default_nettype wire

// ===== src/thermal_pixel_radiometric_correction_unit.sv =====
// ----------------------------------------------------------------------------
// thermal_pixel_radiometric_correction_unit
// Per-pixel emissivity, reflected and atmospheric correction of a
// thermal image stream.
//
// Channels: req_chan carries one raw pixel temperature per beat, rsp_chan
// one corrected temperature plus a saturation flag per beat, both
// valid/ready. The csr port writes emissivity, reflected temperature,
// atmosphere temperature, distance and humidity, one register per cycle.
// Path from an accepted request beat to its response beat: 4 front
// stages, two 32-stage square root pipes, output register.
// Throughput: one pixel per clock while the receiver takes beats and the
// sequencer is idle; every stage holds one pixel.
// Reset and every register write start the coefficient sequencer, which
// rebuilds the constant correction term on one bit-serial multiply and
// divide unit; req_chan.ready stays low until it is done.
// When the receiver stalls, the whole pipe holds and ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_pixel_radiometric_correction_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   tprc_req_if.sink                            req_chan,
   tprc_rsp_if.source                          rsp_chan,
   input  wire                                 csr_wen,
   input  wire  [tprc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [tprc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CORR_W = 24;
   localparam int RW     = tprc_pkg::ROOT_W;
   localparam int K2_W   = tprc_pkg::K2_W;
   localparam logic signed [CORR_W-1:0] LOW_C  = CORR_W'(tprc_pkg::OUT_LOW);
   localparam logic signed [CORR_W-1:0] HIGH_C = CORR_W'(tprc_pkg::OUT_HIGH);
   localparam logic signed [CORR_W-1:0] KEL_C  = CORR_W'(tprc_pkg::KELVIN_K);

   tprc_pkg::md_req_type md_req;
   tprc_pkg::md_rsp_type md_rsp;
   logic                          coef_busy;
   logic [tprc_pkg::SUM_W-1:0]    const_term;

   logic adv;
   logic accept;

   logic                          a_vld_ff;
   logic [tprc_pkg::MAG_W-1:0]    a_mag_ff;
   logic                          b_vld_ff;
   logic [tprc_pkg::SQ_W-1:0]     b_sq_ff;
   logic                          c_vld_ff;
   logic [tprc_pkg::POW_W-1:0]    c_pw_ff;
   logic                          d_vld_ff;
   logic [tprc_pkg::SUM_W-1:0]    d_sum_ff;

   logic [2*tprc_pkg::MAG_W-1:0]  mag_sq;
   logic [tprc_pkg::POW_W-1:0]    sq_sq;

   logic          s_vld;
   logic [RW-1:0] s_root;
   logic          k_vld;
   logic [RW-1:0] k_root;

   logic [K2_W:0]              kp1;
   logic signed [CORR_W-1:0]   corr_w;
   logic signed [tprc_pkg::TEMP_W-1:0] corr_in;
   logic                       sat_in;

   logic                               rsp_vld_ff;
   logic signed [tprc_pkg::TEMP_W-1:0] rsp_corr_ff;
   logic                               rsp_sat_ff;

   tprc_coef u_coef (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .md_req     (md_req),
      .md_rsp     (md_rsp),
      .busy       (coef_busy),
      .const_term (const_term)
   );

   tprc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign adv            = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv && !coef_busy;
   assign accept         = req_chan.valid && req_chan.ready;

   assign mag_sq = a_mag_ff * a_mag_ff;
   assign sq_sq  = b_sq_ff * b_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff <= tprc_pkg::kelvin_mag(req_chan.raw_temp);
         b_sq_ff  <= mag_sq[tprc_pkg::SQ_W+9:10];
         c_pw_ff  <= sq_sq;
         d_sum_ff <= tprc_pkg::SUM_W'(c_pw_ff) + const_term;
      end
   end

   tprc_isqrt u_isqrt_s (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (d_vld_ff),
      .in_value  ({d_sum_ff[tprc_pkg::SUM_W-3:0], 2'b00}),
      .out_valid (s_vld),
      .out_root  (s_root)
   );

   tprc_isqrt u_isqrt_k (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (s_vld),
      .in_value  ({21'b0, s_root, 11'b0}),
      .out_valid (k_vld),
      .out_root  (k_root)
   );

   always_comb begin
      kp1    = {1'b0, k_root[K2_W-1:0]} + (K2_W+1)'(1);
      corr_w = $signed(CORR_W'(kp1[K2_W:1])) - KEL_C;
      if (corr_w < LOW_C) begin
         corr_in = tprc_pkg::TEMP_W'(LOW_C);
         sat_in  = 1'b1;
      end else if (corr_w > HIGH_C) begin
         corr_in = tprc_pkg::TEMP_W'(HIGH_C);
         sat_in  = 1'b1;
      end else begin
         corr_in = tprc_pkg::TEMP_W'(corr_w);
         sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= k_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_corr_ff <= corr_in;
         rsp_sat_ff  <= sat_in;
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.corrected_temp = rsp_corr_ff;
   assign rsp_chan.saturated      = rsp_sat_ff;

   // a register write always reruns the coefficient sequence
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> coef_busy)
      else $error("csr write did not restart coefficient sequencer");

   // a flagged beat sits on one of the range limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_sat_ff |->
         rsp_corr_ff == tprc_pkg::TEMP_W'(LOW_C) || rsp_corr_ff == tprc_pkg::TEMP_W'(HIGH_C))
      else $error("saturated beat not at a range limit");

   // after reset no beat is out and coefficients are rebuilt
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && coef_busy)
      else $error("bad state after reset");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thermal pixel radiometric correction unit.
// Pixels are streamed through the request channel under several idle and
// stall patterns and register settings. A fixed point predictor computes the
// corrected temperature and saturation flag of each accepted beat, and every
// response beat is compared in order against it.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic signed [tprc_pkg::TEMP_W-1:0] temp;
      logic                               sat;
   } pixel_result_type;

   // register indexes with no register behind them
   localparam logic [tprc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [tprc_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic clock;
   logic reset;
   logic                            csr_wen;
   logic [tprc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tprc_pkg::CSR_DATA_W-1:0] csr_wdata;

   tprc_req_if req ();
   tprc_rsp_if rsp ();

   thermal_pixel_radiometric_correction_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow
   logic [tprc_pkg::EMIS_W-1:0]        emis_r;
   logic signed [tprc_pkg::TEMP_W-1:0] refl_r;
   logic signed [tprc_pkg::TEMP_W-1:0] atm_r;
   logic [tprc_pkg::DIST_W-1:0]        dist_r;
   logic [tprc_pkg::HUM_W-1:0]         hum_r;

   pixel_result_type expected_pixels[$];
   int idle_pct;
   int stall_pct;
   int mismatches = 0;
   bit failed = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned kelvin_pow4(logic signed [tprc_pkg::TEMP_W-1:0] t);
      longint k;
      longint unsigned m;
      longint unsigned sq;
      k = longint'(t) + tprc_pkg::KELVIN_K;
      m = (k < 0) ? -k : k;
      sq = (m * m) >> 10;
      return sq * sq;
   endfunction

   function automatic longint unsigned scale_q16(longint unsigned p, longint unsigned c);
      return (p >> 16) * c + (((p & 64'hFFFF) * c) >> 16);
   endfunction

   function automatic longint unsigned transmittance(longint unsigned od,
                                                     longint unsigned h);
      longint unsigned x32;
      longint unsigned acc;
      longint unsigned term;
      x32 = (od * (tprc_pkg::EXP_A + tprc_pkg::EXP_B * h)) >> 16;
      if (x32 >= tprc_pkg::LN2_Q32) return 64'd1 << 31;
      acc = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int n = 1; n <= tprc_pkg::TAYLOR_TERMS; n++) begin
         term = ((term * x32) >> 32) / n;
         if (n % 2 == 1) acc -= term;
         else acc += term;
      end
      if (acc < (64'd1 << 31)) acc = 64'd1 << 31;
      if (acc > (64'd1 << 32)) acc = 64'd1 << 32;
      return acc;
   endfunction

   function automatic pixel_result_type correct_pixel(
         logic signed [tprc_pkg::TEMP_W-1:0] raw);
      longint unsigned e, od, h, tau, cr, ca, total, s, k2, kout;
      longint corr;
      pixel_result_type r;
      e = emis_r;
      if (e < 655) e = 655;
      if (e > 65536) e = 65536;
      od = (dist_r < 26) ? 26 : dist_r;
      h = (hum_r > 65536) ? 65536 : hum_r;
      tau = transmittance(od, h);
      cr = ((65536 - e) << 16) / e;
      ca = (((64'd1 << 32) - tau) << 32) / (e * tau);
      total = kelvin_pow4(raw) + scale_q16(kelvin_pow4(refl_r), cr)
            + scale_q16(kelvin_pow4(atm_r), ca);
      s = root_floor(total << 2);
      k2 = root_floor(s << 11);
      kout = (k2 + 1) >> 1;
      corr = longint'(kout) - tprc_pkg::KELVIN_K;
      r.sat = 1'b0;
      if (corr < tprc_pkg::OUT_LOW) begin
         corr = tprc_pkg::OUT_LOW;
         r.sat = 1'b1;
      end else if (corr > tprc_pkg::OUT_HIGH) begin
         corr = tprc_pkg::OUT_HIGH;
         r.sat = 1'b1;
      end
      r.temp = corr[tprc_pkg::TEMP_W-1:0];
      return r;
   endfunction

   // response checker and receiver stalls
   always @(posedge clock) begin
      pixel_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_pixels.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: temp %0d sat %0d", rsp.corrected_temp,
                        rsp.saturated);
         end else begin
            exp_r = expected_pixels.pop_front();
            if (rsp.corrected_temp !== exp_r.temp || rsp.saturated !== exp_r.sat) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected temp %0d sat %0d, got temp %0d sat %0d",
                           exp_r.temp, exp_r.sat, rsp.corrected_temp, rsp.saturated);
            end
         end
      end
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic drain_pipe();
      req.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tprc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tprc_pkg::CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         tprc_pkg::CSR_EMISSIVITY: emis_r = val[tprc_pkg::EMIS_W-1:0];
         tprc_pkg::CSR_REFLECTED:  refl_r = val[tprc_pkg::TEMP_W-1:0];
         tprc_pkg::CSR_ATMOSPHERE: atm_r  = val[tprc_pkg::TEMP_W-1:0];
         tprc_pkg::CSR_DISTANCE:   dist_r = val[tprc_pkg::DIST_W-1:0];
         tprc_pkg::CSR_HUMIDITY:   hum_r  = val[tprc_pkg::HUM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      csr_wen <= 1'b0;
   endtask

   task automatic write_all(input logic [tprc_pkg::CSR_DATA_W-1:0] em,
                            input logic [tprc_pkg::CSR_DATA_W-1:0] rt,
                            input logic [tprc_pkg::CSR_DATA_W-1:0] at,
                            input logic [tprc_pkg::CSR_DATA_W-1:0] di,
                            input logic [tprc_pkg::CSR_DATA_W-1:0] hu);
      write_reg(tprc_pkg::CSR_EMISSIVITY, em);
      write_reg(tprc_pkg::CSR_REFLECTED, rt);
      write_reg(tprc_pkg::CSR_ATMOSPHERE, at);
      write_reg(tprc_pkg::CSR_DISTANCE, di);
      write_reg(tprc_pkg::CSR_HUMIDITY, hu);
   endtask

   task automatic send_pixel(input logic signed [tprc_pkg::TEMP_W-1:0] raw);
      req.valid    <= 1'b1;
      req.raw_temp <= raw;
      do @(posedge clock); while (!req.ready);
      expected_pixels.insert(expected_pixels.size(), correct_pixel(raw));
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic signed [tprc_pkg::TEMP_W-1:0] random_temp();
      if ($urandom_range(9) < 8)
         return tprc_pkg::TEMP_W'($urandom_range(160000) - 10000);
      return tprc_pkg::TEMP_W'($urandom);
   endfunction

   task automatic test_field_extremes();
      int raws[$] = '{-262144, 262143, -10000, 150000, 0, -27315, -27316, -27314,
                      -54630, -11000, 160000, -1, 1, 2500, 100000, -20000};
      idle_pct = 0;
      stall_pct = 0;
      foreach (raws[i]) send_pixel(tprc_pkg::TEMP_W'(raws[i]));
      drain_pipe();
   endtask

   task automatic test_register_extremes();
      int cfg[5][5] = '{
         '{0, -262144, 262143, 0, 0},
         '{655, 150000, -10000, 26, 65536},
         '{65536, 262143, -262144, 65535, 131071},
         '{131071, -10000, 150000, 25, 65535},
         '{654, 0, 0, 2560, 1}};
      idle_pct = 0;
      stall_pct = 0;
      foreach (cfg[i]) begin
         write_all(tprc_pkg::CSR_DATA_W'(cfg[i][0]), tprc_pkg::CSR_DATA_W'(cfg[i][1]),
                   tprc_pkg::CSR_DATA_W'(cfg[i][2]), tprc_pkg::CSR_DATA_W'(cfg[i][3]),
                   tprc_pkg::CSR_DATA_W'(cfg[i][4]));
         write_reg(CSR_SPARE_LO, 19'h7FFFF);
         write_reg(CSR_SPARE_HI, 19'h0);
         end_writes();
         send_pixel(-19'sd10000);
         send_pixel(19'sd150000);
         send_pixel(random_temp());
         drain_pipe();
      end
   endtask

   task automatic test_random_stream();
      int idle_modes[4]  = '{0, 68, 0, 19};
      int stall_modes[4] = '{0, 0, 68, 19};
      for (int ph = 0; ph < 8; ph++) begin
         write_all(tprc_pkg::CSR_DATA_W'(($urandom_range(3) == 0)
                                            ? $urandom_range(131071)
                                            : $urandom_range(655, 65536)),
                   random_temp(), random_temp(),
                   tprc_pkg::CSR_DATA_W'(($urandom_range(1) == 0)
                                            ? $urandom_range(0, 2000)
                                            : $urandom_range(65535)),
                   tprc_pkg::CSR_DATA_W'(($urandom_range(3) == 0)
                                            ? $urandom_range(131071)
                                            : $urandom_range(65536)));
         end_writes();
         idle_pct  = idle_modes[ph % 4];
         stall_pct = stall_modes[ph % 4];
         repeat (250) send_pixel(random_temp());
         drain_pipe();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.raw_temp = '0;
      idle_pct = 0;
      stall_pct = 0;
      emis_r = 17'd62259;
      refl_r = 19'sd2500;
      atm_r  = 19'sd2500;
      dist_r = 16'd256;
      hum_r  = 17'd32768;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_register_extremes();
      test_random_stream();
      if (!failed) begin
         $display("[thermal_pixel_radiometric_correction_unit] OK");
      end else begin
         $display("[thermal_pixel_radiometric_correction_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[thermal_pixel_radiometric_correction_unit] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tprc_pkg.sv
src/tprc_if.sv
src/tprc_muldiv.sv
src/tprc_coef.sv
src/tprc_isqrt.sv
src/thermal_pixel_radiometric_correction_unit.sv
sim/tb_top.sv
